@@ src/brld_pkg.sv @@
`default_nettype none
package brld_pkg;

	// byte and count widths of the encoded stream
	localparam int ByteW = 8;

	// parse phases, one-hot
	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_VALUE   = 4'b0010,
		PH_LITLEN  = 4'b0100,
		PH_LITERAL = 4'b1000
	} phase_t;

	// stream status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_TRUNCATED = 1'b1;

endpackage
`default_nettype wire

@@ src/byte_run_length_decoder.sv @@
// Byte run-length decoder. Takes the encoded stream one byte per word and
// gives run descriptors (value, repeat count). A nonzero header byte is a
// count and the next byte its value; a zero header is followed by a length
// byte and that many literal bytes, each giving a descriptor with count 1.
// Header and length bytes give no output word, except on the final byte of
// a stream (tlast), which always gives one word: an empty marker with
// count 0 if the byte made no descriptor, and tuser set if the stream ended
// inside an unfinished token. The parse state then returns to its reset
// values. Throughput is one byte per cycle while the output is ready. A
// taken byte is held in the input register and parsed combinationally out
// of it, and its descriptor is registered into the output register once
// that register is free. While an output word waits, one more byte is
// held in the input register and the input stalls.
`default_nettype none
module byte_run_length_decoder
	import brld_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [ByteW-1:0]     s_axis_tdata,  // in_byte
	input  wire logic                 s_axis_tlast,  // end_of_stream
	// output stream
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [2*ByteW-1:0]        m_axis_tdata,  // out_value (low byte), repeat_count (high byte)
	output logic                      m_axis_tlast,  // last_run
	output logic                      m_axis_tuser   // stream_status
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;

	phase_t           phase_q, phase_nxt, phase_adv;
	logic [ByteW-1:0] pend_q, pend_nxt;
	logic [ByteW-1:0] left_q, left_nxt, left_dec;

	logic             have;
	logic [ByteW-1:0] val;
	logic [ByteW-1:0] cnt;
	logic             emit;

	logic             out_valid_q;
	logic [ByteW-1:0] out_value_q;
	logic [ByteW-1:0] out_count_q;
	logic             out_last_q;
	logic             out_status_q;

	logic             out_free;
	logic             fire_s1;
	logic             s_fire;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// parse step for the registered byte
	assign left_dec = left_q - ByteW'(1);

	always_comb begin
		phase_adv = phase_q;
		pend_nxt  = pend_q;
		left_nxt  = left_q;
		have      = 1'b0;
		val       = '0;
		cnt       = '0;
		case (phase_q)
			PH_HEADER: begin
				if (byte_s1 != '0) begin
					pend_nxt  = byte_s1;
					phase_adv = PH_VALUE;
				end else begin
					phase_adv = PH_LITLEN;
				end
			end
			PH_VALUE: begin
				have      = 1'b1;
				val       = byte_s1;
				cnt       = pend_q;
				pend_nxt  = '0;
				phase_adv = PH_HEADER;
			end
			PH_LITLEN: begin
				if (byte_s1 != '0) begin
					left_nxt  = byte_s1;
					phase_adv = PH_LITERAL;
				end else begin
					phase_adv = PH_HEADER;
				end
			end
			PH_LITERAL: begin
				have     = 1'b1;
				val      = byte_s1;
				cnt      = ByteW'(1);
				left_nxt = left_dec;
				if (left_dec == '0) begin
					phase_adv = PH_HEADER;
				end
			end
			default: begin
				phase_adv = PH_HEADER;
			end
		endcase
		phase_nxt = last_s1 ? PH_HEADER : phase_adv;
	end

	assign emit = have || last_s1;

	// parse state, back to reset values after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pend_q  <= '0;
			left_q  <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_nxt;
			pend_q  <= last_s1 ? '0 : pend_nxt;
			left_q  <= last_s1 ? '0 : left_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			out_value_q  <= val;
			out_count_q  <= cnt;
			out_last_q   <= last_s1;
			out_status_q <= (last_s1 && phase_adv != PH_HEADER) ?
				STATUS_TRUNCATED : STATUS_OK;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_count_q, out_value_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_status_q;

	// truncation is only reported on the final word
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == STATUS_TRUNCATED |-> out_last_q)
		else $error("truncation status on a word that is not last");

	// a zero count only appears on the final marker
	a_zero_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_count_q == '0 |-> out_last_q)
		else $error("zero repeat count on a word that is not last");

	// a new stream starts expecting a header
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |=> phase_q == PH_HEADER && pend_q == '0 && left_q == '0)
		else $error("parse state not cleared after final byte");

endmodule
`default_nettype wire

@@ tb/byte_run_length_decoder_test.sv @@
module byte_run_length_decoder_test;
	import brld_pkg::*;

	localparam int RandomWords = 1200;
	localparam int IdleLimit = 2000;
	localparam int DrainCycles = 10;

	// one encoded byte as presented on the input stream
	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             last;
	} enc_byte_t;

	// one run descriptor as seen on the output stream
	typedef struct packed {
		logic [ByteW-1:0] value;
		logic [ByteW-1:0] count;
		logic             last;
		logic             status;
	} run_desc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [ByteW-1:0] s_axis_tdata = '0;  // in_byte
	logic             s_axis_tlast = 1'b0; // end_of_stream

	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [2*ByteW-1:0] m_axis_tdata;  // out_value (low byte), repeat_count (high byte)
	logic               m_axis_tlast;  // last_run
	logic               m_axis_tuser;  // stream_status

	enc_byte_t byte_q[$];
	run_desc_t runs_expected[$];

	// decoder state mirrored by the predictor
	phase_t           dec_phase = PH_HEADER;
	logic [ByteW-1:0] dec_run_len = '0;
	logic [ByteW-1:0] dec_lit_left = '0;

	int n_sent = 0;
	int n_runs = 0;
	int n_markers = 0;
	int n_truncated = 0;
	int n_errors = 0;
	int idle_cycles = 0;

	byte_run_length_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// advance the parse state by one byte and queue the descriptor it gives
	task automatic decode_byte(input logic [ByteW-1:0] b, input logic eos);
		logic      have;
		run_desc_t r;
		have = 1'b0;
		r = '0;
		case (dec_phase)
			PH_HEADER: begin
				if (b != '0) begin
					dec_run_len = b;
					dec_phase = PH_VALUE;
				end else begin
					dec_phase = PH_LITLEN;
				end
			end
			PH_VALUE: begin
				have = 1'b1;
				r.value = b;
				r.count = dec_run_len;
				dec_run_len = '0;
				dec_phase = PH_HEADER;
			end
			PH_LITLEN: begin
				if (b != '0) begin
					dec_lit_left = b;
					dec_phase = PH_LITERAL;
				end else begin
					dec_phase = PH_HEADER;
				end
			end
			default: begin
				have = 1'b1;
				r.value = b;
				r.count = 8'd1;
				dec_lit_left = dec_lit_left - 8'd1;
				if (dec_lit_left == '0)
					dec_phase = PH_HEADER;
			end
		endcase
		// end of stream always gives a word and restarts parsing
		if (eos) begin
			have = 1'b1;
			r.last = 1'b1;
			r.status = (dec_phase != PH_HEADER) ? STATUS_TRUNCATED : STATUS_OK;
			dec_phase = PH_HEADER;
			dec_run_len = '0;
			dec_lit_left = '0;
		end
		if (have)
			runs_expected.push_back(r);
	endtask

	task automatic push_byte(input logic [ByteW-1:0] b, input logic eos);
		enc_byte_t e;
		e.data = b;
		e.last = eos;
		byte_q.push_back(e);
	endtask

	// driver: presents queued bytes with random gaps between words
	always @(posedge clk or negedge arst_n) begin : drive
		static int gap = 0;
		enc_byte_t e;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
				n_sent++;
				gap = ((n_sent % 250) < 50) ? 0 : $urandom_range(0, 5);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap > 0) begin
					gap--;
					s_axis_tvalid <= 1'b0;
				end else if (byte_q.size() > 0) begin
					e = byte_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= e.data;
					s_axis_tlast <= e.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and comparison against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : monitor
		static int stall = 0;
		run_desc_t got;
		run_desc_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.value = m_axis_tdata[ByteW-1:0];
				got.count = m_axis_tdata[2*ByteW-1:ByteW];
				got.last = m_axis_tlast;
				got.status = m_axis_tuser;
				if (runs_expected.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected word: value %02h count %0d last %b status %b",
							got.value, got.count, got.last, got.status);
				end else begin
					want = runs_expected.pop_front();
					if (got !== want) begin
						n_errors++;
						if (n_errors <= 10) begin
							$display("mismatch: expected value %02h count %0d last %b status %b",
								want.value, want.count, want.last, want.status);
							$display("          got value %02h count %0d last %b status %b",
								got.value, got.count, got.last, got.status);
						end
					end
				end
				n_runs++;
				if (got.count == '0)
					n_markers++;
				if (got.status == STATUS_TRUNCATED)
					n_truncated++;
				stall = ((n_runs % 300) < 60) ? 0 : $urandom_range(0, 5);
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("watchdog: no progress for %0d cycles", IdleLimit);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int        n_directed;
		int        kind;
		int        len;
		int        cut;
		bit        broken;
		bit        eos;
		logic [ByteW-1:0] tok[$];

		// longest run, then shortest run with top value
		push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b0);
		// literal of two bytes, then zero literal length
		push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0);
		push_byte(8'hA5, 1'b0); push_byte(8'h5A, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		// stream ends on a run header
		push_byte(8'h05, 1'b1);
		// stream ends on the literal length byte
		push_byte(8'h00, 1'b0); push_byte(8'h04, 1'b1);
		// stream ends on a zero header
		push_byte(8'h00, 1'b1);
		// stream ends on a zero literal length, token complete
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
		// stream ends on a run value
		push_byte(8'h03, 1'b0); push_byte(8'h55, 1'b1);
		// stream ends inside a literal
		push_byte(8'h00, 1'b0); push_byte(8'h03, 1'b0); push_byte(8'h11, 1'b1);
		// stream ends on the last literal byte
		push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h22, 1'b1);
		n_directed = byte_q.size();

		// random tokens: mostly well formed, some cut short, some noise
		while (byte_q.size() < n_directed + RandomWords) begin
			kind = $urandom_range(0, 99);
			tok.delete();
			broken = 1'b0;
			if (kind < 45) begin
				tok.push_back(ByteW'($urandom_range(1, 255)));
				tok.push_back(ByteW'($urandom_range(0, 255)));
			end else if (kind < 80) begin
				len = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 255)
					: $urandom_range(1, 8);
				tok.push_back(8'h00);
				tok.push_back(len[ByteW-1:0]);
				for (int i = 0; i < len; i++)
					tok.push_back(ByteW'($urandom_range(0, 255)));
			end else if (kind < 86) begin
				tok.push_back(8'h00);
				tok.push_back(8'h00);
			end else if (kind < 95) begin
				tok.push_back(ByteW'($urandom_range(0, 255)));
				tok.push_back(ByteW'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					tok.push_back(ByteW'($urandom_range(0, 255)));
				broken = 1'b1;
			end else begin
				push_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				continue;
			end
			if (broken) begin
				cut = $urandom_range(1, tok.size() - 1);
				while (tok.size() > cut)
					void'(tok.pop_back());
			end
			eos = broken || ($urandom_range(0, 9) == 0);
			for (int i = 0; i < tok.size(); i++)
				push_byte(tok[i], eos && (i == tok.size() - 1));
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every byte is taken and every descriptor has come back
		do
			@(negedge clk);
		while (byte_q.size() > 0 || s_axis_tvalid || runs_expected.size() > 0);
		repeat (DrainCycles) @(posedge clk);

		$display("sent %0d encoded bytes in runs, literals, empty tokens and cut streams",
			n_sent);
		$display("checked %0d descriptors, %0d end markers, %0d truncated streams",
			n_runs, n_markers, n_truncated);
		if (n_errors == 0 && runs_expected.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d descriptors missing", n_errors,
				runs_expected.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/brld_pkg.sv
src/byte_run_length_decoder.sv
tb/byte_run_length_decoder_test.sv
